@@ sv/lcd_mode_line_timing_defines.svh @@
// Assertion macros used by the display timing core.
`ifndef LCD_MODE_LINE_TIMING_DEFINES_SVH
`define LCD_MODE_LINE_TIMING_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LMLT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LMLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lcd_mlt_pkg.sv @@
`timescale 1ns / 1ps

package lcd_mlt_pkg;

	// Frame geometry
	localparam int VISIBLE_LINES = 144;
	localparam int LAST_LINE     = 153;

	// Ticks per phase
	localparam logic [7:0] OAM_TICKS    = 8'd20;
	localparam logic [7:0] XFER_TICKS   = 8'd43;
	localparam logic [7:0] HBLANK_TICKS = 8'd51;
	localparam logic [7:0] LINE_TICKS   = 8'd114;
	localparam logic [7:0] GLITCH_TICKS = 8'd19;

	// Phase codes (0..3 match the status mode)
	localparam logic [2:0] PH_HBLANK = 3'd0;
	localparam logic [2:0] PH_VBLANK = 3'd1;
	localparam logic [2:0] PH_OAM    = 3'd2;
	localparam logic [2:0] PH_XFER   = 3'd3;
	localparam logic [2:0] PH_GLITCH = 3'd4;

	// Status mode codes
	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_XFER   = 2'd3;

	// Bit positions in stat_select
	localparam int SEL_HBLANK = 0;
	localparam int SEL_VBLANK = 1;
	localparam int SEL_OAM    = 2;
	localparam int SEL_COIN   = 3;
	localparam int SEL_GLITCH = 4;

	// One result word
	typedef struct packed {
		logic       clear_screen;
		logic       render_line;
		logic       stat_irq;
		logic       vblank_irq;
		logic       coincidence;
		logic [1:0] mode_bits;
		logic [7:0] line_number;
	} res_t;

endpackage

@@ sv/lcd_mlt_core.sv @@
`timescale 1ns / 1ps
`include "lcd_mode_line_timing_defines.svh"

module lcd_mlt_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  logic               lcd_on,
	input  logic [4:0]         stat_select,
	input  logic [7:0]         compare_line,
	output lcd_mlt_pkg::res_t  res
);

	logic [2:0] phase_q, phase_d;
	logic [6:0] tick_q, tick_d;
	logic [7:0] line_q, line_d;
	logic [1:0] mode_q, mode_d;
	logic       irqh_q, irqh_d;
	logic       clrp_q, clrp_d;
	logic [7:0] t;
	logic [8:0] nl;
	logic       coin, cond;

	assign t  = {1'b0, tick_q} + 8'd1;
	assign nl = {1'b0, line_q} + 9'd1;

	// Next state and result for one tick
	always_comb begin
		logic [7:0] tn;
		tn     = t;
		phase_d = phase_q;
		line_d  = line_q;
		mode_d  = mode_q;
		irqh_d  = irqh_q;
		clrp_d  = clrp_q;
		tick_d  = tick_q;
		coin    = 1'b0;
		cond    = 1'b0;
		res     = '0;
		if (!lcd_on) begin
			tick_d = '0;
			line_d = '0;
			mode_d = lcd_mlt_pkg::MODE_HBLANK;
			coin   = (compare_line == 8'd0);
			if (clrp_q) begin
				clrp_d           = 1'b0;
				res.clear_screen = 1'b1;
			end
		end else begin
			clrp_d = 1'b1;
			case (phase_q)
				lcd_mlt_pkg::PH_OAM: begin
					if (t >= lcd_mlt_pkg::OAM_TICKS) begin
						tn      = t - lcd_mlt_pkg::OAM_TICKS;
						phase_d = lcd_mlt_pkg::PH_XFER;
						mode_d  = lcd_mlt_pkg::MODE_XFER;
					end
				end
				lcd_mlt_pkg::PH_XFER: begin
					if (t >= lcd_mlt_pkg::XFER_TICKS) begin
						tn              = t - lcd_mlt_pkg::XFER_TICKS;
						phase_d         = lcd_mlt_pkg::PH_HBLANK;
						mode_d          = lcd_mlt_pkg::MODE_HBLANK;
						res.render_line = 1'b1;
					end
				end
				lcd_mlt_pkg::PH_HBLANK: begin
					if (t >= lcd_mlt_pkg::HBLANK_TICKS) begin
						tn     = t - lcd_mlt_pkg::HBLANK_TICKS;
						line_d = nl[7:0];
						if (nl < 9'(lcd_mlt_pkg::VISIBLE_LINES)) begin
							phase_d = lcd_mlt_pkg::PH_OAM;
							mode_d  = lcd_mlt_pkg::MODE_OAM;
						end else begin
							phase_d        = lcd_mlt_pkg::PH_VBLANK;
							mode_d         = lcd_mlt_pkg::MODE_VBLANK;
							res.vblank_irq = 1'b1;
						end
					end
				end
				lcd_mlt_pkg::PH_VBLANK: begin
					if (t >= lcd_mlt_pkg::LINE_TICKS) begin
						tn = t - lcd_mlt_pkg::LINE_TICKS;
						// past the last line: wrap to the top of the frame
						if (nl > 9'(lcd_mlt_pkg::LAST_LINE)) begin
							line_d  = '0;
							phase_d = lcd_mlt_pkg::PH_OAM;
							mode_d  = lcd_mlt_pkg::MODE_OAM;
						end else begin
							line_d = nl[7:0];
						end
					end
				end
				default: begin
					// glitched first OAM phase, mode bits left alone
					if (t >= lcd_mlt_pkg::GLITCH_TICKS) begin
						tn      = t - lcd_mlt_pkg::GLITCH_TICKS;
						phase_d = lcd_mlt_pkg::PH_XFER;
						mode_d  = lcd_mlt_pkg::MODE_XFER;
					end
				end
			endcase
			tick_d = tn[6:0];
			coin   = (compare_line == line_d);

			// status interrupt condition, edge detected
			cond = coin && stat_select[lcd_mlt_pkg::SEL_COIN];
			case (phase_d)
				lcd_mlt_pkg::PH_HBLANK: cond = cond || stat_select[lcd_mlt_pkg::SEL_HBLANK];
				lcd_mlt_pkg::PH_VBLANK: cond = cond || stat_select[lcd_mlt_pkg::SEL_VBLANK];
				lcd_mlt_pkg::PH_OAM:    cond = cond || stat_select[lcd_mlt_pkg::SEL_OAM];
				lcd_mlt_pkg::PH_GLITCH: cond = cond || stat_select[lcd_mlt_pkg::SEL_GLITCH];
				default:                cond = cond;
			endcase
			if (cond) begin
				if (!irqh_q) begin
					res.stat_irq = 1'b1;
					irqh_d       = 1'b1;
				end
			end else begin
				irqh_d = 1'b0;
			end
		end
		res.line_number = line_d;
		res.mode_bits   = mode_d;
		res.coincidence = coin;
	end

	// Timing state, advanced once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lcd_mlt_pkg::PH_GLITCH;
			tick_q  <= '0;
			line_q  <= '0;
			mode_q  <= lcd_mlt_pkg::MODE_HBLANK;
			irqh_q  <= 1'b0;
			clrp_q  <= 1'b1;
		end else if (acc) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			line_q  <= line_d;
			mode_q  <= mode_d;
			irqh_q  <= irqh_d;
			clrp_q  <= clrp_d;
		end
	end

	`LMLT_ASSERT(a_line_range, clk, arst_n, line_q <= 8'(lcd_mlt_pkg::LAST_LINE), "line out of range")
	`LMLT_ASSERT(a_tick_range, clk, arst_n, tick_q < lcd_mlt_pkg::LINE_TICKS[6:0], "tick count too large")
	`LMLT_ASSERT_NEXT(a_off_clears, clk, arst_n, acc && !lcd_on, tick_q == 7'd0 && line_q == 8'd0 && mode_q == lcd_mlt_pkg::MODE_HBLANK, "disabled tick did not clear counters")
	`LMLT_ASSERT_NEXT(a_render_hblank, clk, arst_n, acc && res.render_line, phase_q == lcd_mlt_pkg::PH_HBLANK, "render pulse without entering hblank")

endmodule

@@ sv/lcd_mlt_out_reg.sv @@
`timescale 1ns / 1ps

module lcd_mlt_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  lcd_mlt_pkg::res_t res,
	output logic              busy,
	output logic              m_tvalid,
	input  logic              m_tready,
	output lcd_mlt_pkg::res_t m_res
);

	logic valid_q;

	// full and not being drained this cycle
	assign busy     = valid_q && !m_tready;
	assign m_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (acc) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (acc) begin
			m_res <= res;
		end
	end

endmodule

@@ sv/lcd_mode_line_timing.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Width  Contents
// s_axis   in   16     one machine-cycle tick: enable, status selects, compare line
// m_axis   out  16     line, mode, coincidence and the pulse flags for that tick
//
// One tick per clock while m_axis is not stalled: the timing state and the output
// register both load at the edge that accepts a word, so its result can be taken from the next cycle on.
// Throughput is set by the single output register, which is refilled as it drains.
// Reset puts the sequencer in the glitched OAM phase, line 0, clear pending.
// A stall on m_axis holds s_tready low until the waiting result is taken.

module lcd_mode_line_timing (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] lcd_on, [5:1] stat_select, [13:6] compare_line, [15:14] zero
	input  logic [15:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] line_number, [9:8] mode_bits, [10] coincidence, [11] vblank_irq,
	// [12] stat_irq, [13] render_line, [14] clear_screen, [15] zero
	output logic [15:0] m_tdata
);

	logic              acc;
	logic              busy;
	lcd_mlt_pkg::res_t res;
	lcd_mlt_pkg::res_t m_res;

	assign s_tready = !busy;
	assign acc      = s_tvalid && s_tready;

	lcd_mlt_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.lcd_on       (s_tdata[0]),
		.stat_select  (s_tdata[5:1]),
		.compare_line (s_tdata[13:6]),
		.res          (res)
	);

	lcd_mlt_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.res      (res),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_res    (m_res)
	);

	assign m_tdata = {1'b0, m_res};

endmodule

@@ sim/lcd_mode_line_timing_check.sv @@
`timescale 1ns / 1ps

// Watches both stream channels, tracks the display timing state for every
// accepted tick word and compares each result word with the oldest prediction.
module lcd_mode_line_timing_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// [0] lcd_on, [5:1] stat_select, [13:6] compare_line, [15:14] zero
	input  logic [15:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] line_number, [9:8] mode_bits, [10] coincidence, [11] vblank_irq,
	// [12] stat_irq, [13] render_line, [14] clear_screen, [15] zero
	input  logic [15:0] m_tdata,
	output int          errors,
	output int          pending
);

	// Sequencer state as the block should hold it
	logic [2:0] seq_phase;
	logic [6:0] tick_cnt;
	logic [7:0] scan_line;
	logic [1:0] stat_mode;
	logic       stat_line_high;
	logic       clear_owed;

	lcd_mlt_pkg::res_t status_words_due[$];

	// One machine-cycle tick: update the state, return the status word it yields
	function automatic lcd_mlt_pkg::res_t advance_timing(input logic lcd,
		input logic [4:0] sel, input logic [7:0] cmp);
		lcd_mlt_pkg::res_t r;
		int   t;
		int   nl;
		logic cond;
		r = '0;
		if (!lcd) begin
			// display off: counters cleared, phase frozen, clear pulse once
			tick_cnt  = '0;
			scan_line = '0;
			stat_mode = lcd_mlt_pkg::MODE_HBLANK;
			r.coincidence = (cmp == 8'd0);
			if (clear_owed) begin
				clear_owed     = 1'b0;
				r.clear_screen = 1'b1;
			end
		end else begin
			clear_owed = 1'b1;
			t = int'(tick_cnt) + 1;
			case (seq_phase)
				lcd_mlt_pkg::PH_OAM: begin
					if (t >= int'(lcd_mlt_pkg::OAM_TICKS)) begin
						t -= int'(lcd_mlt_pkg::OAM_TICKS);
						seq_phase = lcd_mlt_pkg::PH_XFER;
						stat_mode = lcd_mlt_pkg::MODE_XFER;
					end
				end
				lcd_mlt_pkg::PH_XFER: begin
					if (t >= int'(lcd_mlt_pkg::XFER_TICKS)) begin
						t -= int'(lcd_mlt_pkg::XFER_TICKS);
						seq_phase = lcd_mlt_pkg::PH_HBLANK;
						stat_mode = lcd_mlt_pkg::MODE_HBLANK;
						r.render_line = 1'b1;
					end
				end
				lcd_mlt_pkg::PH_HBLANK: begin
					if (t >= int'(lcd_mlt_pkg::HBLANK_TICKS)) begin
						t -= int'(lcd_mlt_pkg::HBLANK_TICKS);
						nl = int'(scan_line) + 1;
						scan_line = 8'(nl);
						if (nl < lcd_mlt_pkg::VISIBLE_LINES) begin
							seq_phase = lcd_mlt_pkg::PH_OAM;
							stat_mode = lcd_mlt_pkg::MODE_OAM;
						end else begin
							seq_phase = lcd_mlt_pkg::PH_VBLANK;
							stat_mode = lcd_mlt_pkg::MODE_VBLANK;
							r.vblank_irq = 1'b1;
						end
					end
				end
				lcd_mlt_pkg::PH_VBLANK: begin
					if (t >= int'(lcd_mlt_pkg::LINE_TICKS)) begin
						t -= int'(lcd_mlt_pkg::LINE_TICKS);
						nl = int'(scan_line) + 1;
						// past the last line: wrap to the top of the frame
						if (nl > lcd_mlt_pkg::LAST_LINE) begin
							scan_line = '0;
							seq_phase = lcd_mlt_pkg::PH_OAM;
							stat_mode = lcd_mlt_pkg::MODE_OAM;
						end else begin
							scan_line = 8'(nl);
						end
					end
				end
				default: begin
					// glitched OAM phase after reset, mode bits untouched on entry
					if (t >= int'(lcd_mlt_pkg::GLITCH_TICKS)) begin
						t -= int'(lcd_mlt_pkg::GLITCH_TICKS);
						seq_phase = lcd_mlt_pkg::PH_XFER;
						stat_mode = lcd_mlt_pkg::MODE_XFER;
					end
				end
			endcase
			tick_cnt = 7'(t);
			r.coincidence = (cmp == scan_line);

			// status line: coincidence plus the select of the current phase
			cond = r.coincidence && sel[lcd_mlt_pkg::SEL_COIN];
			if (seq_phase <= lcd_mlt_pkg::PH_OAM && sel[seq_phase])
				cond = 1'b1;
			else if (seq_phase == lcd_mlt_pkg::PH_GLITCH && sel[lcd_mlt_pkg::SEL_GLITCH])
				cond = 1'b1;
			if (cond) begin
				if (!stat_line_high) begin
					r.stat_irq     = 1'b1;
					stat_line_high = 1'b1;
				end
			end else begin
				stat_line_high = 1'b0;
			end
		end
		r.line_number = scan_line;
		r.mode_bits   = stat_mode;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Predict on every accepted tick word, compare on every accepted result word
	always @(posedge clk or negedge arst_n) begin
		lcd_mlt_pkg::res_t want;
		lcd_mlt_pkg::res_t got;
		lcd_mlt_pkg::res_t predicted;
		if (!arst_n) begin
			seq_phase      = lcd_mlt_pkg::PH_GLITCH;
			tick_cnt       = '0;
			scan_line      = '0;
			stat_mode      = lcd_mlt_pkg::MODE_HBLANK;
			stat_line_high = 1'b0;
			clear_owed     = 1'b1;
			status_words_due.delete();
			pending = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted = advance_timing(s_tdata[0], s_tdata[5:1], s_tdata[13:6]);
				status_words_due = {status_words_due, predicted};
			end
			if (m_tvalid && m_tready) begin
				if (status_words_due.size() == 0) begin
					$error("result word %h with no tick waiting for it", m_tdata);
					errors++;
				end else begin
					want = status_words_due.pop_front();
					got  = lcd_mlt_pkg::res_t'(m_tdata[14:0]);
					check_field("line_number", want.line_number, got.line_number);
					check_field("mode_bits", want.mode_bits, got.mode_bits);
					check_field("coincidence", want.coincidence, got.coincidence);
					check_field("vblank_irq", want.vblank_irq, got.vblank_irq);
					check_field("stat_irq", want.stat_irq, got.stat_irq);
					check_field("render_line", want.render_line, got.render_line);
					check_field("clear_screen", want.clear_screen, got.clear_screen);
					check_field("pad", 0, m_tdata[15]);
				end
			end
			pending = status_words_due.size();
		end
	end

endmodule

@@ sim/lcd_mode_line_timing_test.sv @@
`timescale 1ns / 1ps

module lcd_mode_line_timing_test;

	localparam int LIMIT      = 50_000;
	localparam int DRAIN      = 20;
	localparam int STALL_LEN  = 300;
	localparam int BURST      = 130;
	localparam int STEADY_RUN = 40;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [15:0] s_tdata  = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [15:0] m_tdata;

	int errors;
	int pending;
	int cycles       = 0;
	int tx_idle      = 0;
	int rx_idle      = 0;
	int stall_orders = 0;
	int stall_done   = 0;

	lcd_mode_line_timing u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lcd_mode_line_timing_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: random back-pressure, long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (stall_orders != stall_done) begin
				m_tready <= 1'b0;
				repeat (STALL_LEN) @(posedge clk);
				stall_done++;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	// Offer one tick word after a random gap, return once it is taken
	task automatic send_tick(input logic lcd, input logic [4:0] sel, input logic [7:0] cmp);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, cmp, sel, lcd};
		do @(posedge clk); while (!s_tready);
	endtask

	// Runs of enabled ticks with occasional display-off stretches
	task automatic random_ticks(input int count, input int max_run, input int off_pct);
		int         run;
		logic       lcd;
		logic [4:0] sel;
		logic [7:0] cmp;
		while (count > 0) begin
			lcd = ($urandom_range(99) >= off_pct);
			run = lcd ? $urandom_range(max_run, 1) : $urandom_range(3, 1);
			sel = 5'($urandom);
			cmp = $urandom_range(1) ? 8'($urandom_range(8, 0)) : 8'($urandom);
			for (int i = 0; i < run && count > 0; i++) begin
				if ($urandom_range(9) == 0)
					sel = 5'($urandom);
				if ($urandom_range(19) == 0)
					cmp = 8'($urandom);
				send_tick(lcd, sel, cmp);
				count--;
			end
		end
	endtask

	// Hold off the sender until every expected result word has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// glitched phase with its own select, then coincidence edges
		send_tick(1'b1, 5'h10, 8'h00);
		repeat (9) send_tick(1'b1, 5'h00, 8'hFF);
		send_tick(1'b1, 5'h08, 8'h00);
		// all selects through the end of the glitched phase into transfer
		repeat (8) send_tick(1'b1, 5'h1F, 8'hFF);
		send_tick(1'b1, 5'h1F, 8'h00);
		// display off: clear pulse once, coincidence against line 0
		send_tick(1'b0, 5'h1F, 8'h00);
		send_tick(1'b0, 5'h00, 8'hFF);
		send_tick(1'b1, 5'h00, 8'h00);

		// slow sender, slow receiver
		tx_idle = 36;
		rx_idle = 50;
		random_ticks(BURST, 40, 12);
		drain_results();

		// roles swapped, with a long receiver hold-off
		tx_idle = 50;
		rx_idle = 36;
		stall_orders++;
		random_ticks(BURST, 40, 12);
		drain_results();

		// full rate, another hold-off, then a steady enabled run
		tx_idle = 0;
		rx_idle = 0;
		stall_orders++;
		random_ticks(BURST, 40, 12);
		random_ticks(STEADY_RUN, STEADY_RUN, 0);

		drain_results();
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
